// ----- design/cpfv_pkg.sv -----
// Shared types, constants and the mod-11 check-digit function for the CPF validator.
package cpfv_pkg;

	localparam logic [7:0] CharZero = 8'h30;
	localparam logic [7:0] CharNine = 8'h39;
	localparam logic [3:0] ModBase = 4'd11;
	localparam logic [3:0] LastSumPos = 4'd8;
	localparam logic [3:0] TenthPos = 4'd9;
	localparam logic [3:0] FinalPos = 4'd10;
	localparam logic [3:0] FirstWeightTop = 4'd10;
	localparam logic [3:0] SecondWeightTop = 4'd11;
	// floor(x * RecipMul / 2**RecipShift) underestimates x / 11 by at most one for x < 2048
	localparam logic [6:0] RecipMul = 7'd93;
	localparam int RecipShift = 10;

	typedef enum logic [2:0] {
		StValid  = 3'd0,
		StEqual  = 3'd1,
		StBoth   = 3'd2,
		StFirst  = 3'd3,
		StSecond = 3'd4
	} status_t;

	typedef struct packed {
		status_t status;
		logic [3:0] first_check;
		logic [3:0] second_check;
	} result_t;

	function automatic logic [3:0] check_digit(input logic [10:0] sum);
		logic [17:0] prod;
		logic [6:0] quo;
		logic [10:0] rem;
		logic [3:0] r;
		prod = 18'(sum) * 18'(RecipMul);
		quo = prod[RecipShift +: 7];
		rem = sum - 11'(quo) * 11'(ModBase);
		if (rem >= 11'(ModBase)) begin
			rem = rem - 11'(ModBase);
		end
		r = rem[3:0];
		if (r < 4'd2) begin
			return 4'd0;
		end
		return ModBase - r;
	endfunction

endpackage

// ----- design/cpfv_accum.sv -----
// Digit counter, weighted sums and the result decision for one CPF number.
module cpfv_accum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           char_code,
	output logic                 emit,
	output cpfv_pkg::result_t    res
);

	logic [3:0] digit_count_q;
	logic [8:0] first_sum_q;
	logic [9:0] second_sum_q;
	logic [3:0] first_digit_calc_q;
	logic [3:0] tenth_digit_seen_q;

	logic        is_digit;
	logic [7:0]  diff;
	logic [3:0]  d;
	logic [3:0]  w1;
	logic [3:0]  w2;
	logic [7:0]  p1;
	logic [7:0]  p2;
	logic [3:0]  c2;
	logic        bad1;
	logic        bad2;

	assign is_digit = (char_code >= cpfv_pkg::CharZero) && (char_code <= cpfv_pkg::CharNine);
	assign diff = char_code - cpfv_pkg::CharZero;
	assign d = diff[3:0];
	assign w1 = cpfv_pkg::FirstWeightTop - digit_count_q;
	assign w2 = cpfv_pkg::SecondWeightTop - digit_count_q;
	assign p1 = 8'(d) * 8'(w1);
	assign p2 = 8'(d) * 8'(w2);
	assign emit = is_digit && (digit_count_q >= cpfv_pkg::FinalPos);

	assign c2 = cpfv_pkg::check_digit(11'(second_sum_q) + 11'({first_digit_calc_q, 1'b0}));
	assign bad1 = (first_digit_calc_q != tenth_digit_seen_q);
	assign bad2 = (c2 != d);

	always_comb begin
		res.first_check = first_digit_calc_q;
		res.second_check = c2;
		if (first_digit_calc_q == c2) begin
			res.status = cpfv_pkg::StEqual;
		end else if (bad1 && bad2) begin
			res.status = cpfv_pkg::StBoth;
		end else if (bad1) begin
			res.status = cpfv_pkg::StFirst;
		end else if (bad2) begin
			res.status = cpfv_pkg::StSecond;
		end else begin
			res.status = cpfv_pkg::StValid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			first_sum_q <= '0;
			second_sum_q <= '0;
			first_digit_calc_q <= '0;
			tenth_digit_seen_q <= '0;
		end else if (step && is_digit) begin
			if (digit_count_q <= cpfv_pkg::LastSumPos) begin
				first_sum_q <= first_sum_q + 9'(p1);
				second_sum_q <= second_sum_q + 10'(p2);
				digit_count_q <= digit_count_q + 4'd1;
			end else if (digit_count_q == cpfv_pkg::TenthPos) begin
				tenth_digit_seen_q <= d;
				first_digit_calc_q <= cpfv_pkg::check_digit(11'(first_sum_q));
				digit_count_q <= cpfv_pkg::FinalPos;
			end else begin
				digit_count_q <= '0;
				first_sum_q <= '0;
				second_sum_q <= '0;
				first_digit_calc_q <= '0;
				tenth_digit_seen_q <= '0;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= cpfv_pkg::FinalPos)
		else $error("digit count out of range");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> digit_count_q == 4'd0 && first_sum_q == 9'd0 && second_sum_q == 10'd0)
		else $error("state not cleared after result");

	a_nondigit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && !is_digit |=> $stable(digit_count_q) && $stable(first_sum_q))
		else $error("non-digit changed state");

	a_check_range: assert property (@(posedge clk) disable iff (!arst_n)
		first_digit_calc_q <= 4'd9 && c2 <= 4'd9)
		else $error("check digit out of range");

endmodule

// ----- design/cpf_check_digit_validator.sv -----
// Top level of the CPF check-digit validator: input stage, accumulator and result register.
//
// Usage:
//   Input channel (char_valid/char_ready/char_code) takes one ASCII byte per word.
//   Bytes other than '0'..'9' are dropped without effect. Eleven digits make one
//   CPF number; the eleventh produces one word on the result channel
//   (result_valid/result_ready with status, first_check, second_check).
//   status: 0 valid, 1 computed check digits equal, 2 both given digits wrong,
//   3 first wrong, 4 second wrong.
// Timing:
//   One byte per cycle sustained while no final digit waits on a stalled result. A byte
//   is registered into stage 1; when it advances, the accumulator processes it and
//   loads the output register at the same edge.
// Reset:
//   arst_n clears the digit count, sums and both valid flags; the block starts a
//   fresh number.
// Stall:
//   While a result waits, non-digit and non-final bytes keep flowing; only a byte
//   that would produce a second result holds in stage 1, and char_ready drops.
module cpf_check_digit_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_code,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [2:0] status,
	output logic [3:0] first_check,
	output logic [3:0] second_check
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              out_valid_q;
	cpfv_pkg::result_t res_q;

	logic              emit;
	logic              out_free;
	logic              advance;
	cpfv_pkg::result_t res;

	assign out_free = !out_valid_q || result_ready;
	assign advance = valid_s1 && (!emit || out_free);
	assign char_ready = !valid_s1 || advance;

	cpfv_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.emit      (emit),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && emit) begin
			res_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign status = res_q.status;
	assign first_check = res_q.first_check;
	assign second_check = res_q.second_check;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_ready && valid_s1 && emit |-> !char_ready)
		else $error("final digit taken while result stalled");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_ready |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !emit |-> char_ready)
		else $error("pipeline stalled on a non-result word");

endmodule
